[hdl/iss_pkg.sv]
// ----------------------------------------------------------------------------
// iss_pkg
// Types and codes shared by the intake and shooter sequencer.
// ----------------------------------------------------------------------------
package iss_pkg;

    // Field widths fixed by the stream format
    localparam int CMD_W   = 3;
    localparam int SPEED_W = 16;
    localparam int TICKS_W = 16;
    localparam int POS_W   = 16;
    localparam int ARM_W   = 3;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_ROLL_IN  = 3'd2,
        CMD_ROLL_OUT = 3'd3,
        CMD_SHOOT    = 3'd4,
        CMD_RESET    = 3'd5
    } t_cmd;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_ROLL_IN  = 6'b000010,
        PH_ADJUST   = 6'b000100,
        PH_ROLL_OUT = 6'b001000,
        PH_SPINUP   = 6'b010000,
        PH_FIRE     = 6'b100000
    } t_phase;

    localparam logic [PHASE_W-1:0] PC_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PC_ROLL_IN  = 3'd1;
    localparam logic [PHASE_W-1:0] PC_ADJUST   = 3'd2;
    localparam logic [PHASE_W-1:0] PC_ROLL_OUT = 3'd3;
    localparam logic [PHASE_W-1:0] PC_SPINUP   = 3'd4;
    localparam logic [PHASE_W-1:0] PC_FIRE     = 3'd5;

    localparam logic [ARM_W-1:0] ARM_NONE   = 3'd0;
    localparam logic [ARM_W-1:0] ARM_INTAKE = 3'd1;
    localparam logic [ARM_W-1:0] ARM_CLOSE  = 3'd2;
    localparam logic [ARM_W-1:0] ARM_SHOOT  = 3'd3;
    localparam logic [ARM_W-1:0] ARM_RAW    = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROLL_IN_SPEED  = 3'd0,
        REG_ADJUST_SPEED   = 3'd1,
        REG_ROLL_OUT_SPEED = 3'd2,
        REG_SHOOT_SPEED    = 3'd3,
        REG_FEED_SPEED     = 3'd4,
        REG_EJECT_TICKS    = 3'd5,
        REG_SPINUP_TICKS   = 3'd6,
        REG_FIRE_TICKS     = 3'd7
    } t_cfg_reg;

    // One-hot phase to the reported phase number
    function automatic logic [PHASE_W-1:0] f_phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_IDLE:     code = PC_IDLE;
            PH_ROLL_IN:  code = PC_ROLL_IN;
            PH_ADJUST:   code = PC_ADJUST;
            PH_ROLL_OUT: code = PC_ROLL_OUT;
            PH_SPINUP:   code = PC_SPINUP;
            PH_FIRE:     code = PC_FIRE;
            default:     code = PC_IDLE;
        endcase
        return code;
    endfunction

endpackage

[hdl/intake_shooter_sequencer.sv]
// ----------------------------------------------------------------------------
// intake_shooter_sequencer
// Six-phase sequencer for a ball intake and a flywheel shooter.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser cmd, tdata fields
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata result fields
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  Every transfer on s_axis yields exactly one result transfer on m_axis,
//  offered in the next cycle; a new item is taken every cycle while results drain.
//  The rate is set by the single result register: s_axis stalls only while
//  that register holds a result m_axis has not taken.
//  Reset (synchronous, active low) returns the phase to idle, clears timer,
//  drive levels, shoot target and all configuration registers.
//  Configuration writes are always taken (o_cfg_ready is tied high).
//
module intake_shooter_sequencer
    import iss_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int DRIVE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] close select, [16:1] arm target position, [17] line_break,
    // [18] arm_at_target, [23:19] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] cmd
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] intake_drive, [31:16] flywheel_drive, [34:32] arm_request,
    // [50:35] arm_raw_target, [53:51] phase_out, [55:54] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SPEED_W-1:0]     i_cfg_data
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam int DRIVE_HI = (1 << (DRIVE_BITS - 1)) - 1;
    localparam int DRIVE_LO = -DRIVE_HI - 1;

    // Clamp a 16-bit speed to the held-level width
    function automatic logic signed [DRIVE_BITS-1:0] f_sat(input logic signed [SPEED_W-1:0] v);
        logic signed [31:0] w;
        logic signed [31:0] r;
        w = 32'(v);
        if (w > DRIVE_HI) begin
            r = DRIVE_HI;
        end else if (w < DRIVE_LO) begin
            r = DRIVE_LO;
        end else begin
            r = w;
        end
        return r[DRIVE_BITS-1:0];
    endfunction

    // Held level to its 16-bit output form (low 16 bits of the signed value)
    function automatic logic [SPEED_W-1:0] f_drive_out(input logic signed [DRIVE_BITS-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[SPEED_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [SPEED_W-1:0] r_roll_in_speed;
    logic signed [SPEED_W-1:0] r_adjust_speed;
    logic signed [SPEED_W-1:0] r_roll_out_speed;
    logic signed [SPEED_W-1:0] r_fly_speed;
    logic signed [SPEED_W-1:0] r_feed_speed;
    logic [TICKS_W-1:0]        r_eject_ticks;
    logic [TICKS_W-1:0]        r_spinup_ticks;
    logic [TICKS_W-1:0]        r_fire_ticks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_in_speed  <= '0;
            r_adjust_speed   <= '0;
            r_roll_out_speed <= '0;
            r_fly_speed      <= '0;
            r_feed_speed     <= '0;
            r_eject_ticks    <= '0;
            r_spinup_ticks   <= '0;
            r_fire_ticks     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ROLL_IN_SPEED:  r_roll_in_speed  <= i_cfg_data;
                REG_ADJUST_SPEED:   r_adjust_speed   <= i_cfg_data;
                REG_ROLL_OUT_SPEED: r_roll_out_speed <= i_cfg_data;
                REG_SHOOT_SPEED:    r_fly_speed      <= i_cfg_data;
                REG_FEED_SPEED:     r_feed_speed     <= i_cfg_data;
                REG_EJECT_TICKS:    r_eject_ticks    <= i_cfg_data;
                REG_SPINUP_TICKS:   r_spinup_ticks   <= i_cfg_data;
                REG_FIRE_TICKS:     r_fire_ticks     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    t_phase                       r_phase,   n_phase;
    logic [TIMER_BITS-1:0]        r_elapsed, n_elapsed;
    logic                         r_timer_on, n_timer_on;
    logic                         r_close,   n_close;
    logic [POS_W-1:0]             r_raw,     n_raw;
    logic signed [DRIVE_BITS-1:0] r_intake,  n_intake;
    logic signed [DRIVE_BITS-1:0] r_fly,     n_fly;
    logic [ARM_W-1:0]             n_req;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic in_xfer;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Input fields
    t_cmd             cmd;
    logic             sel_close;
    logic [POS_W-1:0] target_pos;
    logic             ball;
    logic             arrived;
    assign cmd        = t_cmd'(s_axis_tuser);
    assign sel_close  = s_axis_tdata[0];
    assign target_pos = s_axis_tdata[16:1];
    assign ball       = !s_axis_tdata[17];
    assign arrived    = s_axis_tdata[18];

    // Timer after its saturating advance
    logic [TIMER_BITS-1:0] el_inc;
    assign el_inc = (r_timer_on && (r_elapsed != TIMER_MAX)) ? r_elapsed + 1'b1 : r_elapsed;

    logic eject_done, spinup_done, fire_done;
    assign eject_done  = 32'(el_inc) >= 32'(r_eject_ticks);
    assign spinup_done = 32'(el_inc) >= 32'(r_spinup_ticks);
    assign fire_done   = 32'(el_inc) >= 32'(r_fire_ticks);

    // Reverse flywheel for ejecting: -(shot speed / 2), truncated toward zero
    logic signed [SPEED_W:0]   shoot_ext, shoot_half, eject_neg;
    logic signed [SPEED_W-1:0] eject_fly;
    assign shoot_ext  = 17'(r_fly_speed);
    assign shoot_half = $signed(shoot_ext + 17'(r_fly_speed[SPEED_W-1])) >>> 1;
    assign eject_neg  = -shoot_half;
    assign eject_fly  = eject_neg[SPEED_W-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_timer_on = r_timer_on;
        n_close    = r_close;
        n_raw      = r_raw;
        n_intake   = r_intake;
        n_fly      = r_fly;
        n_req      = ARM_NONE;

        unique case (cmd)
            CMD_TICK: begin
                n_elapsed = el_inc;
                unique case (r_phase)
                    PH_ROLL_IN: begin
                        n_intake = f_sat(r_roll_in_speed);
                        if (ball) begin
                            n_intake = '0;
                            n_phase  = PH_ADJUST;
                        end
                    end
                    PH_ADJUST: begin
                        n_intake = f_sat(r_adjust_speed);
                        if (!ball) begin
                            n_intake   = '0;
                            n_phase    = PH_IDLE;
                            n_elapsed  = '0;
                            n_timer_on = 1'b0;
                        end
                    end
                    PH_ROLL_OUT: begin
                        // timer starts here, counts from the next tick
                        if (arrived) begin
                            n_timer_on = 1'b1;
                            n_intake   = f_sat(r_roll_out_speed);
                            n_fly      = f_sat(eject_fly);
                            if (eject_done) begin
                                n_intake   = '0;
                                n_phase    = PH_IDLE;
                                n_elapsed  = '0;
                                n_timer_on = 1'b0;
                            end
                        end
                    end
                    PH_SPINUP: begin
                        n_fly = f_sat(r_fly_speed);
                        if (r_close) begin
                            n_req = ARM_CLOSE;
                        end else if (r_raw != '0) begin
                            n_req = ARM_RAW;
                        end else begin
                            n_req = ARM_SHOOT;
                        end
                        if (spinup_done && arrived) begin
                            n_phase    = PH_FIRE;
                            n_intake   = f_sat(r_feed_speed);
                            n_elapsed  = '0;
                            n_timer_on = 1'b1;
                        end
                    end
                    PH_FIRE: begin
                        n_intake = f_sat(r_feed_speed);
                        n_fly    = f_sat(r_fly_speed);
                        if (fire_done) begin
                            n_phase    = PH_IDLE;
                            n_req      = ARM_INTAKE;
                            n_intake   = '0;
                            n_fly      = '0;
                            n_elapsed  = '0;
                            n_timer_on = 1'b0;
                        end
                    end
                    default: begin
                        n_phase    = PH_IDLE;
                        n_intake   = '0;
                        n_fly      = '0;
                        n_elapsed  = '0;
                        n_timer_on = 1'b0;
                    end
                endcase
            end
            CMD_STOP: begin
                n_phase    = PH_IDLE;
                n_intake   = '0;
                n_fly      = '0;
                n_elapsed  = '0;
                n_timer_on = 1'b0;
            end
            CMD_ROLL_IN: begin
                n_req   = ARM_INTAKE;
                n_phase = PH_ROLL_IN;
            end
            CMD_ROLL_OUT: begin
                n_req     = ARM_INTAKE;
                n_phase   = PH_ROLL_OUT;
                n_elapsed = '0;
            end
            CMD_SHOOT: begin
                n_phase    = PH_SPINUP;
                n_close    = sel_close;
                n_raw      = sel_close ? '0 : target_pos;
                n_elapsed  = '0;
                n_timer_on = 1'b1;
            end
            CMD_RESET: begin
                n_phase    = PH_IDLE;
                n_elapsed  = '0;
                n_timer_on = 1'b0;
            end
            default: ;  // unused codes leave everything alone
        endcase

        n_out_data = {2'b00,
                      f_phase_code(n_phase),
                      (n_req == ARM_RAW) ? n_raw : {POS_W{1'b0}},
                      n_req,
                      f_drive_out(n_fly),
                      f_drive_out(n_intake)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_elapsed  <= '0;
            r_timer_on <= 1'b0;
            r_close    <= 1'b0;
            r_raw      <= '0;
            r_intake   <= '0;
            r_fly      <= '0;
        end else if (in_xfer) begin
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_timer_on <= n_timer_on;
            r_close    <= n_close;
            r_raw      <= n_raw;
            r_intake   <= n_intake;
            r_fly      <= n_fly;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
